// ===== rtl/core/rsi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types and constants of the ray-sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int FIELD_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int RADIUS_W   = 31;
  localparam int MAT_REGS   = 6;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0_LO = 3'd0,
    CFG_ROW0_HI = 3'd1,
    CFG_ROW1_LO = 3'd2,
    CFG_ROW1_HI = 3'd3,
    CFG_ROW2_LO = 3'd4,
    CFG_ROW2_HI = 3'd5,
    CFG_RADIUS  = 3'd6
  } cfg_index_t;

  // reset: identity matrix, zero translation, unit radius
  localparam logic [CFG_DATA_W-1:0] ROW0_LO_RST = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] ROW0_HI_RST = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW1_LO_RST = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW1_HI_RST = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW2_LO_RST = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW2_HI_RST = 64'h0000_0000_0001_0000;
  localparam logic [RADIUS_W-1:0]   RADIUS_RST  = 31'h0001_0000;

  typedef struct packed {
    logic signed [FIELD_W-1:0] origin_x;
    logic signed [FIELD_W-1:0] origin_y;
    logic signed [FIELD_W-1:0] origin_z;
    logic signed [FIELD_W-1:0] dir_x;
    logic signed [FIELD_W-1:0] dir_y;
    logic signed [FIELD_W-1:0] dir_z;
    logic signed [FIELD_W-1:0] t_min;
    logic signed [FIELD_W-1:0] t_max;
  } ray_in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [FIELD_W-1:0] t_hit;
  } ray_out_t;

endpackage

// ===== rtl/core/rsi_xform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_xform
// Input register, then the 3x4 affine transform of origin and direction:
// one stage of products, one stage of rounded and saturated sums.
// ----------------------------------------------------------------------------
module rsi_xform import rsi_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             in_valid,
  input  ray_in_t                          in_data,
  input  logic [MAT_REGS-1:0][CFG_DATA_W-1:0] mat,
  output logic                             valid,
  output logic [2:0][W-1:0]                o,
  output logic [2:0][W-1:0]                d,
  output logic [W-1:0]                     tmin,
  output logic [W-1:0]                     tmax
);

  localparam int P  = 2 * W;
  localparam int SW = 2 * W + 4;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);

  // clamp a 32-bit field to the word
  function automatic logic [W-1:0] sat_field(input logic [FIELD_W-1:0] v);
    logic uni;
    uni = (&v[FIELD_W-1:W-1]) | ~(|v[FIELD_W-1:W-1]);
    if (uni) return v[W-1:0];
    else if (v[FIELD_W-1]) return {1'b1, {(W-1){1'b0}}};
    else return {1'b0, {(W-1){1'b1}}};
  endfunction

  // shift out the fraction (sum already holds the rounding half) and clamp
  function automatic logic [W-1:0] rnd_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] sh;
    logic                 uni;
    sh  = s >>> F;
    uni = (&sh[SW-1:W-1]) | ~(|sh[SW-1:W-1]);
    if (uni) return sh[W-1:0];
    else if (sh[SW-1]) return {1'b1, {(W-1){1'b0}}};
    else return {1'b0, {(W-1){1'b1}}};
  endfunction

  logic signed [W-1:0] m [3][4];
  logic                v0, v1;
  logic signed [W-1:0] wo [3];
  logic signed [W-1:0] wd [3];
  logic [W-1:0]        tmn0, tmx0, tmn1, tmx1;
  logic signed [P-1:0] pm [3][3];
  logic signed [P-1:0] pd [3][3];
  logic signed [W-1:0] tr [3];

  // matrix entries from the config words
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m[i][0] = $signed(sat_field(mat[2*i][31:0]));
      m[i][1] = $signed(sat_field(mat[2*i][63:32]));
      m[i][2] = $signed(sat_field(mat[2*i+1][31:0]));
      m[i][3] = $signed(sat_field(mat[2*i+1][63:32]));
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      valid <= 1'b0;
    end else if (adv) begin
      v0    <= in_valid;
      v1    <= v0;
      valid <= v1;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      wo[0] <= $signed(sat_field(in_data.origin_x));
      wo[1] <= $signed(sat_field(in_data.origin_y));
      wo[2] <= $signed(sat_field(in_data.origin_z));
      wd[0] <= $signed(sat_field(in_data.dir_x));
      wd[1] <= $signed(sat_field(in_data.dir_y));
      wd[2] <= $signed(sat_field(in_data.dir_z));
      tmn0  <= sat_field(in_data.t_min);
      tmx0  <= sat_field(in_data.t_max);
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pm[i][k] <= m[i][k] * wo[k];
          pd[i][k] <= m[i][k] * wd[k];
        end
        tr[i] <= m[i][3];
      end
      tmn1 <= tmn0;
      tmx1 <= tmx0;
      for (int i = 0; i < 3; i++) begin
        o[i] <= rnd_sat(SW'(pm[i][0]) + SW'(pm[i][1]) + SW'(pm[i][2])
                        + (SW'(tr[i]) <<< F) + HALF);
        d[i] <= rnd_sat(SW'(pd[i][0]) + SW'(pd[i][1]) + SW'(pd[i][2]) + HALF);
      end
      tmin <= tmn1;
      tmax <= tmx1;
    end
  end

endmodule

// ===== rtl/core/rsi_quad.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_quad
// Quadratic coefficients a = d.d, h = o.d, c = o.o - r^2 and the
// discriminant h*h - a*c, over four register stages.
// ----------------------------------------------------------------------------
module rsi_quad import rsi_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [2:0][W-1:0]   o,
  input  logic [2:0][W-1:0]   d,
  input  logic [W-1:0]        in_tmin,
  input  logic [W-1:0]        in_tmax,
  input  logic [RADIUS_W-1:0] radius,
  output logic                valid,
  output logic [2*W-1:0]      disc,
  output logic [W-1:0]        a,
  output logic [W-1:0]        h,
  output logic [W-1:0]        c,
  output logic [W-1:0]        tmin,
  output logic [W-1:0]        tmax,
  output logic                nohit
);

  localparam int P  = 2 * W;
  localparam int SW = 2 * W + 4;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);

  function automatic logic [W-1:0] sat_field(input logic [FIELD_W-1:0] v);
    logic uni;
    uni = (&v[FIELD_W-1:W-1]) | ~(|v[FIELD_W-1:W-1]);
    if (uni) return v[W-1:0];
    else if (v[FIELD_W-1]) return {1'b1, {(W-1){1'b0}}};
    else return {1'b0, {(W-1){1'b1}}};
  endfunction

  function automatic logic [W-1:0] rnd_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] sh;
    logic                 uni;
    sh  = s >>> F;
    uni = (&sh[SW-1:W-1]) | ~(|sh[SW-1:W-1]);
    if (uni) return sh[W-1:0];
    else if (sh[SW-1]) return {1'b1, {(W-1){1'b0}}};
    else return {1'b0, {(W-1){1'b1}}};
  endfunction

  logic signed [W-1:0] r;
  logic                v3, v4, v5;
  logic signed [P-1:0] dd [3];
  logic signed [P-1:0] od [3];
  logic signed [P-1:0] oo [3];
  logic signed [P-1:0] rr;
  logic [W-1:0]        tmn3, tmx3, tmn4, tmx4, tmn5, tmx5;
  logic signed [W-1:0] a4, h4, c4, a5, h5, c5;
  logic signed [P-1:0] hh, ac;
  logic                apos;
  logic signed [P:0]   diff;

  assign r    = $signed(sat_field({1'b0, radius}));
  assign diff = (P+1)'(hh) - (P+1)'(ac);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3    <= 1'b0;
      v4    <= 1'b0;
      v5    <= 1'b0;
      valid <= 1'b0;
    end else if (adv) begin
      v3    <= in_valid;
      v4    <= v3;
      v5    <= v4;
      valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // dot-product terms
      for (int k = 0; k < 3; k++) begin
        dd[k] <= $signed(d[k]) * $signed(d[k]);
        od[k] <= $signed(o[k]) * $signed(d[k]);
        oo[k] <= $signed(o[k]) * $signed(o[k]);
      end
      rr   <= r * r;
      tmn3 <= in_tmin;
      tmx3 <= in_tmax;
      // rounded coefficients
      a4   <= $signed(rnd_sat(SW'(dd[0]) + SW'(dd[1]) + SW'(dd[2]) + HALF));
      h4   <= $signed(rnd_sat(SW'(od[0]) + SW'(od[1]) + SW'(od[2]) + HALF));
      c4   <= $signed(rnd_sat(SW'(oo[0]) + SW'(oo[1]) + SW'(oo[2]) - SW'(rr) + HALF));
      tmn4 <= tmn3;
      tmx4 <= tmx3;
      // discriminant products
      hh   <= h4 * h4;
      ac   <= a4 * c4;
      apos <= (a4 > 0);
      a5   <= a4;
      h5   <= h4;
      c5   <= c4;
      tmn5 <= tmn4;
      tmx5 <= tmx4;
      // discriminant and early reject
      disc  <= diff[P-1:0];
      nohit <= !apos || diff[P];
      a     <= a5;
      h     <= h5;
      c     <= c5;
      tmin  <= tmn5;
      tmax  <= tmx5;
    end
  end

endmodule

// ===== rtl/core/rsi_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined floor square root, one result bit per stage, with a sideband
// that travels alongside.
// ----------------------------------------------------------------------------
module rsi_sqrt #(
  parameter int W    = 32,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [2*W-1:0]  rad,
  input  logic [SB_W-1:0] in_sb,
  output logic            valid,
  output logic [W-1:0]    root,
  output logic [SB_W-1:0] sb
);

  logic [W-1:0]    vr;
  logic [W+1:0]    rem [W];
  logic [W-1:0]    rt  [W];
  logic [2*W-1:0]  rd  [W];
  logic [SB_W-1:0] sbr [W];
  logic [W+1:0]    rem_next [W];
  logic [W-1:0]    rt_next  [W];
  logic [2*W-1:0]  rd_next  [W];

  // one trial subtraction per stage
  always_comb begin
    for (int j = 0; j < W; j++) begin
      logic [W+1:0]   pr;
      logic [W-1:0]   prt;
      logic [2*W-1:0] prd;
      logic [W+1:0]   sh;
      logic [W+1:0]   tr;
      pr  = (j == 0) ? '0 : rem[j-1];
      prt = (j == 0) ? '0 : rt[j-1];
      prd = (j == 0) ? rad : rd[j-1];
      sh  = {pr[W-1:0], prd[2*W-1:2*W-2]};
      tr  = {prt, 2'b01};
      if (sh >= tr) begin
        rem_next[j] = sh - tr;
        rt_next[j]  = {prt[W-2:0], 1'b1};
      end else begin
        rem_next[j] = sh;
        rt_next[j]  = {prt[W-2:0], 1'b0};
      end
      rd_next[j] = {prd[2*W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= '0;
    end else if (adv) begin
      vr <= {vr[W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < W; j++) begin
        rem[j] <= rem_next[j];
        rt[j]  <= rt_next[j];
        rd[j]  <= rd_next[j];
        sbr[j] <= (j == 0) ? in_sb : sbr[j-1];
      end
    end
  end

  assign valid = vr[W-1];
  assign root  = rt[W-1];
  assign sb    = sbr[W-1];

endmodule

// ===== rtl/core/rsi_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Quotients are truncated toward zero and signed at the output.
// ----------------------------------------------------------------------------
module rsi_div #(
  parameter int N    = 49,
  parameter int M    = 33,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [1:0][N-1:0] num,
  input  logic [1:0][M-1:0] den,
  input  logic [1:0]        neg,
  input  logic [SB_W-1:0]   in_sb,
  output logic              valid,
  output logic [1:0][N:0]   quo,
  output logic [SB_W-1:0]   sb
);

  logic [N-1:0]            vr;
  logic [1:0][M-1:0]       rem [N];
  logic [1:0][N-1:0]       qd  [N];
  logic [1:0][M-1:0]       dn  [N];
  logic [1:0]              ng  [N];
  logic [SB_W-1:0]         sbr [N];
  logic [1:0][M-1:0]       rem_next [N];
  logic [1:0][N-1:0]       qd_next  [N];

  // shift in one dividend bit, subtract if it fits
  always_comb begin
    for (int j = 0; j < N; j++) begin
      for (int l = 0; l < 2; l++) begin
        logic [M-1:0] pr;
        logic [N-1:0] pq;
        logic [M-1:0] pd;
        logic [M:0]   rx;
        pr = (j == 0) ? '0 : rem[j-1][l];
        pq = (j == 0) ? num[l] : qd[j-1][l];
        pd = (j == 0) ? den[l] : dn[j-1][l];
        rx = {pr, pq[N-1]};
        if (rx >= {1'b0, pd}) begin
          rem_next[j][l] = M'(rx - {1'b0, pd});
          qd_next[j][l]  = {pq[N-2:0], 1'b1};
        end else begin
          rem_next[j][l] = rx[M-1:0];
          qd_next[j][l]  = {pq[N-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= '0;
    end else if (adv) begin
      vr <= {vr[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < N; j++) begin
        rem[j] <= rem_next[j];
        qd[j]  <= qd_next[j];
        dn[j]  <= (j == 0) ? den : dn[j-1];
        ng[j]  <= (j == 0) ? neg : ng[j-1];
        sbr[j] <= (j == 0) ? in_sb : sbr[j-1];
      end
    end
  end

  // apply sign
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quo[l] = ng[N-1][l] ? ((N+1)'(0) - {1'b0, qd[N-1][l]}) : {1'b0, qd[N-1][l]};
    end
  end

  assign valid = vr[N-1];
  assign sb    = sbr[N-1];

endmodule

// ===== rtl/core/ray_sphere_intersect.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle; the whole pipeline holds while out_stall is
// high with a result waiting in the output register.
// The square root (one bit per stage) and the divider (one quotient bit per
// stage) set the depth. Reset (rst, synchronous) empties the pipeline and loads
// the identity matrix with zero translation and unit radius.
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// World ray to sphere-local space, quadratic solve in the stable q form,
// nearest root inside [t_min, t_max].
// ----------------------------------------------------------------------------
module ray_sphere_intersect import rsi_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ray_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ray_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int W    = WORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int N    = W + 1 + F;
  localparam int M    = W + 1;
  localparam int QW   = W + 2;
  localparam int SQ_W = 5 * W + 1;
  localparam int DV_W = 2 * W + 1;

  logic                             adv;
  logic [MAT_REGS-1:0][CFG_DATA_W-1:0] mat;
  logic [RADIUS_W-1:0]              radius;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mat[CFG_ROW0_LO] <= ROW0_LO_RST;
      mat[CFG_ROW0_HI] <= ROW0_HI_RST;
      mat[CFG_ROW1_LO] <= ROW1_LO_RST;
      mat[CFG_ROW1_HI] <= ROW1_HI_RST;
      mat[CFG_ROW2_LO] <= ROW2_LO_RST;
      mat[CFG_ROW2_HI] <= ROW2_HI_RST;
      radius           <= RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ROW0_LO, CFG_ROW0_HI, CFG_ROW1_LO,
        CFG_ROW1_HI, CFG_ROW2_LO, CFG_ROW2_HI: mat[cfg_index] <= cfg_data;
        CFG_RADIUS: radius <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: everything moves when the output slot can take an item
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // transform
  logic             xf_valid;
  logic [2:0][W-1:0] xf_o, xf_d;
  logic [W-1:0]     xf_tmin, xf_tmax;

  rsi_xform #(.W(W), .F(F)) u_xform (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(in_valid), .in_data(in_data), .mat(mat),
    .valid(xf_valid), .o(xf_o), .d(xf_d), .tmin(xf_tmin), .tmax(xf_tmax)
  );

  // coefficients and discriminant
  logic           qd_valid, qd_nohit;
  logic [2*W-1:0] qd_disc;
  logic [W-1:0]   qd_a, qd_h, qd_c, qd_tmin, qd_tmax;

  rsi_quad #(.W(W), .F(F)) u_quad (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(xf_valid), .o(xf_o), .d(xf_d),
    .in_tmin(xf_tmin), .in_tmax(xf_tmax), .radius(radius),
    .valid(qd_valid), .disc(qd_disc), .a(qd_a), .h(qd_h), .c(qd_c),
    .tmin(qd_tmin), .tmax(qd_tmax), .nohit(qd_nohit)
  );

  // square root
  logic            sq_valid;
  logic [W-1:0]    sq_root;
  logic [SQ_W-1:0] sq_sb;
  logic signed [W-1:0] sq_a, sq_h, sq_c;
  logic [W-1:0]    sq_tmin, sq_tmax;
  logic            sq_nohit;

  rsi_sqrt #(.W(W), .SB_W(SQ_W)) u_sqrt (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(qd_valid), .rad(qd_disc),
    .in_sb({qd_a, qd_h, qd_c, qd_tmin, qd_tmax, qd_nohit}),
    .valid(sq_valid), .root(sq_root), .sb(sq_sb)
  );

  assign {sq_a, sq_h, sq_c, sq_tmin, sq_tmax, sq_nohit} = sq_sb;

  // q = -(h + sign(h) * root)
  logic                 qs_valid, qs_nohit;
  logic signed [QW-1:0] qs_q;
  logic signed [W-1:0]  qs_a, qs_c;
  logic [W-1:0]         qs_tmin, qs_tmax;
  logic signed [QW-1:0] q_next;

  assign q_next = sq_h[W-1] ? ($signed({2'b00, sq_root}) - QW'(sq_h))
                            : (QW'(0) - (QW'(sq_h) + $signed({2'b00, sq_root})));

  always_ff @(posedge clk) begin
    if (rst) begin
      qs_valid <= 1'b0;
    end else if (adv) begin
      qs_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qs_q     <= q_next;
      qs_a     <= sq_a;
      qs_c     <= sq_c;
      qs_tmin  <= sq_tmin;
      qs_tmax  <= sq_tmax;
      qs_nohit <= sq_nohit || (q_next == '0);
    end
  end

  // divider operands: t0 = q / a, t1 = c / q
  logic [QW-1:0]     q_mag;
  logic [M-1:0]      c_ext, c_mag;
  logic [1:0][N-1:0] dv_num;
  logic [1:0][M-1:0] dv_den;
  logic [1:0]        dv_neg;

  assign q_mag  = qs_q[QW-1] ? (QW'(0) - qs_q) : qs_q;
  assign c_ext  = M'(qs_c);
  assign c_mag  = qs_c[W-1] ? (M'(0) - c_ext) : c_ext;
  assign dv_num = {{c_mag, {F{1'b0}}}, {q_mag[M-1:0], {F{1'b0}}}};
  assign dv_den = {q_mag[M-1:0], {1'b0, qs_a}};
  assign dv_neg = {qs_c[W-1] ^ qs_q[QW-1], qs_q[QW-1]};

  logic              dv_valid;
  logic [1:0][N:0]   dv_quo;
  logic [DV_W-1:0]   dv_sb;
  logic signed [W-1:0] dv_tmin, dv_tmax;
  logic              dv_nohit;

  rsi_div #(.N(N), .M(M), .SB_W(DV_W)) u_div (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(qs_valid), .num(dv_num), .den(dv_den), .neg(dv_neg),
    .in_sb({qs_tmin, qs_tmax, qs_nohit}),
    .valid(dv_valid), .quo(dv_quo), .sb(dv_sb)
  );

  assign {dv_tmin, dv_tmax, dv_nohit} = dv_sb;

  // order the roots and pick the nearest one inside the interval
  logic signed [N:0] t0, t1, lo, hi, tmn, tmx, nearest;
  logic              hit;

  always_comb begin
    t0  = $signed(dv_quo[0]);
    t1  = $signed(dv_quo[1]);
    tmn = (N+1)'(dv_tmin);
    tmx = (N+1)'(dv_tmax);
    if (t0 > t1) begin
      lo = t1;
      hi = t0;
    end else begin
      lo = t0;
      hi = t1;
    end
    nearest = (lo < tmn) ? hi : lo;
    hit     = !dv_nohit && !(lo > tmx) && !(hi < tmn) && !((lo < tmn) && (hi > tmx));
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.hit   <= hit;
      out_data.t_hit <= hit ? $signed(nearest[FIELD_W-1:0]) : '0;
    end
  end

endmodule

// ===== rtl/core/rsi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks of the intersection pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rsi_checker import rsi_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input ray_out_t out_data
);

  // a miss always reports a zero parameter
  miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.t_hit == '0)
    else $error("miss with nonzero t_hit");

  // input side holds only when a result waits
  stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall out of step with output");

  // reset empties the output
  reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // a stalled item holds
  out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled item changed");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);
